[rtl/rars_pkg.sv]
package rars_pkg;

    localparam int unsigned DEF_SIZE        = 1024;
    localparam int unsigned DEF_MAX_UPDATES = 256;
    localparam int unsigned IDX_W           = 11;
    localparam int unsigned VAL_W           = 64;
    localparam int unsigned CNT_RESET       = 1024;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_IDX  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_WR,
        S_TREE_RD,
        S_TREE_ACC,
        S_UPD_RD,
        S_UPD_MUL,
        S_UPD_ACC,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take;       // capture input word
        logic clr_step;   // clear one tree node, advance clear pointer
        logic load_rd;    // read node at load pointer
        logic load_wr;    // write node + value, climb one level
        logic tree_rd;    // issue reads for current walk level
        logic tree_acc;   // accumulate read data, advance walk level
        logic upd_rd;     // read update entry k
        logic upd_mul;    // overlap times amount
        logic upd_acc;    // accumulate product, advance k
        logic upd_store;  // append update entry
        logic out_load;   // load output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic       clr_done;
        logic [1:0] op;
        logic       idx_bad;
        logic       full;
        logic       reversed;
        logic       load_last;   // node pointer reached root
        logic       walk_done;
        logic       upd_done;
    } t_stat;

endpackage

[rtl/range_add_range_sum_table.sv]
// Range sum table with deferred range add. Loads add a value into a leaf and
// every ancestor of a sum tree (log2(SIZE)+1 read-modify-write steps, each a
// read state and a write state); range adds are appended to an update list in
// one step and report when the result register is free; queries walk the tree
// bottom-up for up to log2(SIZE)+1 levels, a read state and an accumulate state
// per level, then scan every stored update in three steps each (read, multiply,
// accumulate). After reset the tree is cleared one node per cycle, all 2*SIZE
// nodes, before the first word is taken; element_count writes are taken at any
// time. One word is in work at a time; the result register frees the input
// side as soon as it is loaded.
module range_add_range_sum_table #(
    parameter int unsigned SIZE        = rars_pkg::DEF_SIZE,
    parameter int unsigned MAX_UPDATES = rars_pkg::DEF_MAX_UPDATES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [rars_pkg::IDX_W-1:0]  i_start_index,
    input  logic [rars_pkg::IDX_W-1:0]  i_end_index,
    input  logic [rars_pkg::VAL_W-1:0]  i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rars_pkg::VAL_W-1:0]  o_range_sum,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rars_pkg::IDX_W-1:0]  i_cfg_data
);
    import rars_pkg::*;

    t_cmd             cmd;
    t_stat            stat;
    logic [IDX_W-1:0] r_count;
    logic [IDX_W-1:0] limit;

    assign o_cfg_ready = 1'b1;
    assign limit = (r_count > IDX_W'(SIZE)) ? IDX_W'(SIZE) : r_count;

    // element count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= IDX_W'(CNT_RESET);
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // output valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    rars_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_busy (o_out_valid && i_out_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rars_dp #(.SIZE(SIZE), .MAX_UPDATES(MAX_UPDATES)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_limit       (limit),
        .i_operation   (i_operation),
        .i_start_index (i_start_index),
        .i_end_index   (i_end_index),
        .i_value       (i_value),
        .o_sum         (o_range_sum),
        .o_status      (o_status)
    );
endmodule

[rtl/rars_ctrl.sv]
module rars_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_busy,
    input  rars_pkg::t_stat i_stat,
    output rars_pkg::t_cmd  o_cmd
);
    import rars_pkg::*;

    t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                // decide from captured word
                if (i_stat.idx_bad || i_stat.op == OP_NONE) begin
                    if (!i_out_busy) begin
                        o_cmd.out_load = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.op == OP_LOAD) begin
                    n_state = S_LOAD_RD;
                end else if (i_stat.op == OP_ADD) begin
                    if (!i_out_busy) begin
                        o_cmd.out_load  = 1'b1;
                        o_cmd.upd_store = !i_stat.full;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.reversed) begin
                    if (!i_out_busy) begin
                        o_cmd.out_load = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_TREE_RD;
                end
            end
            S_LOAD_RD: begin
                o_cmd.load_rd = 1'b1;
                n_state = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_cmd.load_wr = 1'b1;
                n_state = i_stat.load_last ? S_UPD_ACC : S_LOAD_RD;
            end
            S_TREE_RD: begin
                if (i_stat.walk_done) begin
                    n_state = S_UPD_RD;
                end else begin
                    o_cmd.tree_rd = 1'b1;
                    n_state = S_TREE_ACC;
                end
            end
            S_TREE_ACC: begin
                o_cmd.tree_acc = 1'b1;
                n_state = S_TREE_RD;
            end
            S_UPD_RD: begin
                if (i_stat.upd_done) begin
                    n_state = S_UPD_ACC;
                end else begin
                    o_cmd.upd_rd = 1'b1;
                    n_state = S_UPD_MUL;
                end
            end
            S_UPD_MUL: begin
                o_cmd.upd_mul = 1'b1;
                n_state = S_UPD_ACC;
            end
            S_UPD_ACC: begin
                // finishing state for load and query
                if (i_stat.op == OP_QUERY && !i_stat.upd_done) begin
                    o_cmd.upd_acc = 1'b1;
                    n_state = S_UPD_RD;
                end else if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

[rtl/rars_dp.sv]
module rars_dp #(
    parameter int unsigned SIZE        = rars_pkg::DEF_SIZE,
    parameter int unsigned MAX_UPDATES = rars_pkg::DEF_MAX_UPDATES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rars_pkg::t_cmd            i_cmd,
    output rars_pkg::t_stat           o_stat,
    input  logic [rars_pkg::IDX_W-1:0] i_limit,
    input  logic [1:0]                i_operation,
    input  logic [rars_pkg::IDX_W-1:0] i_start_index,
    input  logic [rars_pkg::IDX_W-1:0] i_end_index,
    input  logic [rars_pkg::VAL_W-1:0] i_value,
    output logic [rars_pkg::VAL_W-1:0] o_sum,
    output logic [1:0]                o_status
);
    import rars_pkg::*;

    localparam int unsigned NW = $clog2(2 * SIZE);          // node address width
    localparam int unsigned EW = $clog2(SIZE + 1);          // element index width
    localparam int unsigned UW = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;
    localparam int unsigned CW = $clog2(MAX_UPDATES + 1);
    localparam int unsigned LW = EW + 1;                     // overlap length width
    localparam logic [NW:0] NODES = (NW + 1)'(2 * SIZE);

    // tree memory and update list memories
    logic [VAL_W-1:0] r_tree [2*SIZE];
    logic [EW-1:0]    r_us   [MAX_UPDATES];
    logic [EW-1:0]    r_ue   [MAX_UPDATES];
    logic [VAL_W-1:0] r_ua   [MAX_UPDATES];

    logic [1:0]       r_op;
    logic [IDX_W-1:0] r_s, r_e;
    logic [VAL_W-1:0] r_v;
    logic [NW:0]      r_clr;
    logic [NW-1:0]    r_node;
    logic [NW:0]      r_a, r_b;
    logic [VAL_W-1:0] r_ta, r_tb, r_acc, r_prod;
    logic             r_ta_v, r_tb_v;
    logic [CW-1:0]    r_cnt, r_k;
    logic [EW-1:0]    r_ks, r_ke;
    logic [VAL_W-1:0] r_ka;
    logic [VAL_W-1:0] r_rd;

    logic s_bad, e_bad, lo_is_s;
    logic [EW-1:0] lo, hi, os, oe;
    logic [LW-1:0] olen;
    logic          ovl;

    assign s_bad = (r_s == '0) || (r_s > i_limit);
    assign e_bad = (r_e == '0) || (r_e > i_limit);
    assign lo_is_s = (r_s <= r_e);
    assign lo = EW'(lo_is_s ? r_s : r_e);
    assign hi = EW'(lo_is_s ? r_e : r_s);
    assign ovl = !(r_ke < lo || r_ks > hi);
    assign os = (r_ks > lo) ? r_ks : lo;
    assign oe = (r_ke < hi) ? r_ke : hi;
    assign olen = LW'(oe) - LW'(os) + LW'(1);

    assign o_stat.clr_done  = (r_clr == NODES - (NW + 1)'(1));
    assign o_stat.op        = r_op;
    assign o_stat.idx_bad   = (r_op == OP_LOAD) ? s_bad : (s_bad || e_bad);
    assign o_stat.full      = (r_cnt >= CW'(MAX_UPDATES));
    assign o_stat.reversed  = (r_s > r_e);
    assign o_stat.load_last = (r_node == NW'(1));
    assign o_stat.walk_done = (r_a > r_b);
    assign o_stat.upd_done  = (r_k >= r_cnt);

    // tree memory: clear sweep, read-modify-write, walk reads of two nodes at once
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) r_tree[r_clr[NW-1:0]] <= '0;
        if (i_cmd.load_wr)  r_tree[r_node] <= r_rd + r_v;
        if (i_cmd.load_rd)  r_rd <= r_tree[r_node];
        if (i_cmd.tree_rd) begin
            r_ta <= r_tree[r_a[NW-1:0]];
            r_tb <= r_tree[r_b[NW-1:0]];
        end
    end

    // update list memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd_store) begin
            r_us[r_cnt[UW-1:0]] <= lo;
            r_ue[r_cnt[UW-1:0]] <= hi;
            r_ua[r_cnt[UW-1:0]] <= r_v;
        end
        if (i_cmd.upd_rd) begin
            r_ks <= r_us[r_k[UW-1:0]];
            r_ke <= r_ue[r_k[UW-1:0]];
            r_ka <= r_ua[r_k[UW-1:0]];
        end
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + (NW + 1)'(1);
            if (i_cmd.upd_store) r_cnt <= r_cnt + CW'(1);
        end
    end

    // capture word and run walks
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op   <= i_operation;
            r_s    <= i_start_index;
            r_e    <= i_end_index;
            r_v    <= i_value;
            r_node <= NW'(i_start_index) + NW'(SIZE - 1);
            r_a    <= (NW + 1)'(i_start_index) + (NW + 1)'(SIZE - 1);
            r_b    <= (NW + 1)'(i_end_index) + (NW + 1)'(SIZE - 1);
            r_acc  <= '0;
            r_k    <= '0;
            r_prod <= '0;
        end
        if (i_cmd.load_wr) r_node <= r_node >> 1;
        if (i_cmd.tree_rd) begin
            r_ta_v <= r_a[0];
            r_tb_v <= !r_b[0];
        end
        if (i_cmd.tree_acc) begin
            r_acc <= r_acc + (r_ta_v ? r_ta : '0) + (r_tb_v ? r_tb : '0);
            r_a   <= (r_a + (NW + 1)'(r_ta_v)) >> 1;
            r_b   <= (r_b - (NW + 1)'(r_tb_v)) >> 1;
        end
        if (i_cmd.upd_mul) r_prod <= ovl ? VAL_W'(olen) * r_ka : '0;
        if (i_cmd.upd_acc) begin
            r_acc  <= r_acc + r_prod;
            r_prod <= '0;
            r_k    <= r_k + CW'(1);
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (o_stat.idx_bad && r_op != OP_NONE) begin
                o_sum    <= '0;
                o_status <= ST_IDX;
            end else if (r_op == OP_ADD && o_stat.full) begin
                o_sum    <= '0;
                o_status <= ST_FULL;
            end else if (r_op == OP_QUERY && !o_stat.reversed) begin
                o_sum    <= r_acc + r_prod;
                o_status <= ST_OK;
            end else begin
                o_sum    <= '0;
                o_status <= ST_OK;
            end
        end
    end
endmodule
